// ===== rtl/core/jise_pkg.sv =====
// shared types and constants for the integer stack execute core
// no dependencies; imported by every module of the core
package jise_pkg;

	// default sizes of the operand stack and the local-variable file
	localparam int STACK_DEPTH_DEF = 64;
	localparam int LOCAL_COUNT_DEF = 256;

	// fixed field widths
	localparam int WORD_W = 32;
	localparam int PC_W   = 16;
	localparam int IMM_W  = 16;

	// decoded operation codes
	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_ADD   = 4'd1,
		OP_MUL   = 4'd2,
		OP_LOAD  = 4'd3,
		OP_STORE = 4'd4,
		OP_DUP   = 4'd5,
		OP_POP   = 4'd6,
		OP_INC   = 4'd7,
		OP_IFEQ  = 4'd8,
		OP_IFNE  = 4'd9,
		OP_IFLT  = 4'd10,
		OP_IFGT  = 4'd11,
		OP_IFLE  = 4'd12,
		OP_IFGE  = 4'd13,
		OP_GOTO  = 4'd14
	} op_t;

	// fault codes
	typedef enum logic [1:0] {
		FAULT_OK    = 2'd0,
		FAULT_UNDER = 2'd1,
		FAULT_OVER  = 2'd2
	} fault_t;

	// sign-extend a 16-bit immediate to a stack word
	function automatic logic [WORD_W-1:0] sext_imm(input logic [IMM_W-1:0] v);
		return {{(WORD_W-IMM_W){v[IMM_W-1]}}, v};
	endfunction

endpackage

// ===== rtl/core/jise_stack_mem.sv =====
// operand stack storage: one write port, two registered read ports
// depends on jise_pkg for the word width
module jise_stack_mem import jise_pkg::*; #(
	parameter int DEPTH = STACK_DEPTH_DEF,
	parameter int AW    = $clog2(STACK_DEPTH_DEF)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr_a,
	input  logic [AW-1:0]     rd_addr_b,
	output logic [WORD_W-1:0] rd_data_a,
	output logic [WORD_W-1:0] rd_data_b,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// two read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== rtl/core/jise_local_mem.sv =====
// local-variable file: one read and one write port, per-slot valid bits
// so unwritten slots read as zero; bypass for a write in the read cycle
// depends on jise_pkg for the word width
module jise_local_mem import jise_pkg::*; #(
	parameter int COUNT = LOCAL_COUNT_DEF,
	parameter int IW    = $clog2(LOCAL_COUNT_DEF)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IW-1:0]     rd_idx,
	output logic [WORD_W-1:0] rd_value,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_idx,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [COUNT];
	logic [COUNT-1:0]  valid_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_valid_q;
	logic [IW-1:0]     rd_idx_q;
	logic              lw_valid_q;
	logic [IW-1:0]     lw_idx_q;
	logic [WORD_W-1:0] lw_data_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			rd_idx_q  <= rd_idx;
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	// most recent write, used as bypass for a read issued at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr_en) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_idx_q  <= wr_idx;
			lw_data_q <= wr_data;
		end
	end

	// read result: newest write wins, unwritten slots are zero
	always_comb begin
		if (lw_valid_q && (lw_idx_q == rd_idx_q)) begin
			rd_value = lw_data_q;
		end else if (rd_valid_q) begin
			rd_value = rd_data_q;
		end else begin
			rd_value = '0;
		end
	end

endmodule

// ===== rtl/core/jvm_integer_stack_execute_core.sv =====
// Integer stack-machine execute core. Takes one decoded instruction word per cycle while the
// result side is not stalled and returns one result word per instruction (next address, stack
// top, depth, fault), registered through the execute stage and the output register. The stack
// pointer is updated when the word is accepted, the same edge issues the stack reads (entries
// below the top) and the local read, and the execute stage then computes and writes back while
// the next word's reads go out. The stack top lives in a register; a local written at the edge
// that issues a read of it is bypassed. Locals read as zero after reset through per-slot valid
// bits, so no clearing pass is needed and the core is ready right after reset.
// depends on jise_pkg, jise_stack_mem and jise_local_mem
module jvm_integer_stack_execute_core import jise_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int LOCAL_COUNT = LOCAL_COUNT_DEF,
	localparam int SP_W = $clog2(STACK_DEPTH + 1),
	localparam int SA_W = $clog2(STACK_DEPTH),
	localparam int LI_W = $clog2(LOCAL_COUNT)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               op,
	input  logic signed [IMM_W-1:0]  imm,
	input  logic [7:0]               local_index,
	input  logic signed [PC_W-1:0]   branch_offset,
	input  logic [PC_W-1:0]          inst_addr,
	input  logic [1:0]               inst_len,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PC_W-1:0]          next_addr,
	output logic signed [WORD_W-1:0] top_value,
	output logic [SP_W-1:0]          depth,
	output logic [1:0]               fault
);

	// state
	logic [SP_W-1:0]   sp_q;
	logic [WORD_W-1:0] tos_q;

	// accept-side decode
	op_t             op_c;
	logic [1:0]      need_c;
	logic            grows_c;
	fault_t          fault_c;
	logic [SP_W-1:0] sp_next_c;
	logic            lok_c;
	logic [PC_W-1:0] fall_c;
	logic [PC_W-1:0] target_c;
	logic [PC_W-1:0] next_c;
	logic            in_fire;

	// execute stage
	logic              s1_valid_q;
	op_t               op_s1;
	logic [IMM_W-1:0]  imm_s1;
	logic [LI_W-1:0]   li_s1;
	logic              lok_s1;
	fault_t            fault_s1;
	logic [SP_W-1:0]   sp_new_s1;
	logic [PC_W-1:0]   next_s1;
	logic [PC_W-1:0]   target_s1;
	logic              s1_fire;

	// execute datapath
	logic [WORD_W-1:0] stk_a;
	logic [WORD_W-1:0] stk_c;
	logic [WORD_W-1:0] loc_v;
	logic [WORD_W-1:0] prod;
	logic              take;
	logic [WORD_W-1:0] top_c;
	logic [WORD_W-1:0] tos_new;
	logic              stk_we;
	logic              stk_push;
	logic [SA_W-1:0]   stk_wa;
	logic              loc_we;
	logic [WORD_W-1:0] loc_wd;

	// output register
	logic              out_valid_q;
	logic [PC_W-1:0]   next_addr_q;
	logic [WORD_W-1:0] top_value_q;
	logic [SP_W-1:0]   depth_q;
	fault_t            fault_q;

	assign op_c    = op_t'(op);
	assign s1_fire = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_fire;
	assign in_fire  = in_valid && in_ready;

	// operand needs and growth per operation
	always_comb begin
		need_c  = 2'd0;
		grows_c = 1'b0;
		case (op_c)
			OP_ADD, OP_MUL, OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGT, OP_IFLE, OP_IFGE: begin
				need_c = 2'd2;
			end
			OP_STORE, OP_POP: begin
				need_c = 2'd1;
			end
			OP_DUP: begin
				need_c  = 2'd1;
				grows_c = 1'b1;
			end
			OP_PUSH, OP_LOAD: begin
				grows_c = 1'b1;
			end
			default: begin
				need_c  = 2'd0;
				grows_c = 1'b0;
			end
		endcase
	end

	// fault check and new stack pointer, both known at accept
	always_comb begin
		if (sp_q < SP_W'(need_c)) begin
			fault_c = FAULT_UNDER;
		end else if (grows_c && (sp_q >= SP_W'(STACK_DEPTH))) begin
			fault_c = FAULT_OVER;
		end else begin
			fault_c = FAULT_OK;
		end
	end

	always_comb begin
		sp_next_c = sp_q;
		if (fault_c == FAULT_OK) begin
			case (op_c)
				OP_PUSH, OP_LOAD, OP_DUP: sp_next_c = sp_q + SP_W'(1);
				OP_ADD, OP_MUL, OP_STORE, OP_POP: sp_next_c = sp_q - SP_W'(1);
				OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGT, OP_IFLE, OP_IFGE: begin
					sp_next_c = sp_q - SP_W'(2);
				end
				default: sp_next_c = sp_q;
			endcase
		end
	end

	// addresses: fall-through, branch target, next unless a branch decides (own address on a fault)
	assign lok_c    = {1'b0, local_index} < 9'(LOCAL_COUNT);
	assign fall_c   = inst_addr + PC_W'(inst_len);
	assign target_c = inst_addr + $unsigned(branch_offset);

	always_comb begin
		if (fault_c != FAULT_OK) begin
			next_c = inst_addr;
		end else if (op_c == OP_GOTO) begin
			next_c = target_c;
		end else begin
			next_c = fall_c;
		end
	end

	// stack pointer and execute-stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q       <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				sp_q <= sp_next_c;
			end
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// execute-stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= op_c;
			imm_s1    <= imm;
			li_s1     <= local_index[LI_W-1:0];
			lok_s1    <= lok_c;
			fault_s1  <= fault_c;
			sp_new_s1 <= sp_next_c;
			next_s1   <= next_c;
			target_s1 <= target_c;
		end
	end

	// operand stack: reads the two entries under the top
	jise_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (SA_W)
	) u_stack (
		.clk       (clk),
		.rd_en     (in_fire),
		.rd_addr_a (SA_W'(sp_q - SP_W'(2))),
		.rd_addr_b (SA_W'(sp_q - SP_W'(3))),
		.rd_data_a (stk_a),
		.rd_data_b (stk_c),
		.wr_en     (stk_we),
		.wr_addr   (stk_wa),
		.wr_data   (top_c)
	);

	// local-variable file
	jise_local_mem #(
		.COUNT (LOCAL_COUNT),
		.IW    (LI_W)
	) u_locals (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_fire),
		.rd_idx   (local_index[LI_W-1:0]),
		.rd_value (loc_v),
		.wr_en    (loc_we),
		.wr_idx   (li_s1),
		.wr_data  (loc_wd)
	);

	// arithmetic and branch decision, no branch on a faulting instruction
	assign prod = stk_a * tos_q;

	always_comb begin
		take = 1'b0;
		if (fault_s1 == FAULT_OK) begin
			case (op_s1)
				OP_IFEQ: take = (stk_a == tos_q);
				OP_IFNE: take = (stk_a != tos_q);
				OP_IFLT: take = ($signed(stk_a) < $signed(tos_q));
				OP_IFGT: take = ($signed(tos_q) < $signed(stk_a));
				OP_IFLE: take = !($signed(tos_q) < $signed(stk_a));
				OP_IFGE: take = !($signed(stk_a) < $signed(tos_q));
				default: take = 1'b0;
			endcase
		end
	end

	// new top of stack
	always_comb begin
		top_c    = tos_q;
		stk_push = 1'b0;
		if (fault_s1 == FAULT_OK) begin
			case (op_s1)
				OP_PUSH: begin
					top_c    = sext_imm(imm_s1);
					stk_push = 1'b1;
				end
				OP_ADD: begin
					top_c    = stk_a + tos_q;
					stk_push = 1'b1;
				end
				OP_MUL: begin
					top_c    = prod;
					stk_push = 1'b1;
				end
				OP_LOAD: begin
					top_c    = lok_s1 ? loc_v : '0;
					stk_push = 1'b1;
				end
				OP_DUP: begin
					top_c    = tos_q;
					stk_push = 1'b1;
				end
				OP_STORE, OP_POP: top_c = stk_a;
				OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGT, OP_IFLE, OP_IFGE: top_c = stk_c;
				default: top_c = tos_q;
			endcase
		end
	end

	assign tos_new = (sp_new_s1 == '0) ? '0 : top_c;

	// write-back of stack top and locals
	assign stk_we = s1_fire && stk_push;
	assign stk_wa = SA_W'(sp_new_s1 - SP_W'(1));
	assign loc_we = s1_fire && (fault_s1 == FAULT_OK) && lok_s1 &&
		((op_s1 == OP_STORE) || (op_s1 == OP_INC));
	assign loc_wd = (op_s1 == OP_STORE) ? tos_q : (loc_v + sext_imm(imm_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tos_q <= '0;
		end else if (s1_fire) begin
			tos_q <= tos_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			next_addr_q <= take ? target_s1 : next_s1;
			top_value_q <= tos_new;
			depth_q     <= sp_new_s1;
			fault_q     <= fault_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign next_addr = next_addr_q;
	assign top_value = $signed(top_value_q);
	assign depth     = depth_q;
	assign fault     = fault_q;

	// depth never passes the stack size
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack size");

	// a faulting instruction writes nothing back
	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && (fault_s1 != FAULT_OK) |-> !stk_we && !loc_we)
		else $error("write-back on a faulting instruction");

	// overflow only with a full stack
	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (fault_c == FAULT_OVER) |-> sp_q == SP_W'(STACK_DEPTH))
		else $error("overflow with free entries");

	// an empty stack reports a zero top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (depth_q == '0) |-> top_value_q == '0)
		else $error("nonzero top on empty stack");

endmodule

// ===== dv/jvm_integer_stack_execute_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the integer stack execute core: directed and random instruction
// words, an in-bench execution model of stack and locals, and a field-by-field result check
// depends on jise_pkg and jvm_integer_stack_execute_core
module jvm_integer_stack_execute_core_tb;
	import jise_pkg::*;

	localparam int STACK_WORDS   = STACK_DEPTH_DEF;
	localparam int LOCAL_SLOTS   = LOCAL_COUNT_DEF;
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_PER_PH = 340;
	localparam logic [3:0] OP_UNUSED = 4'hf;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] imm;
		logic [7:0]  lidx;
		logic [15:0] boff;
		logic [15:0] addr;
		logic [1:0]  len;
	} insn_t;

	typedef struct packed {
		logic [15:0] next_addr;
		logic [31:0] top;
		logic [6:0]  depth;
		logic [1:0]  fault;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  op = '0;
	logic [15:0] imm = '0;
	logic [7:0]  local_index = '0;
	logic [15:0] branch_offset = '0;
	logic [15:0] inst_addr = '0;
	logic [1:0]  inst_len = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] next_addr;
	logic [31:0] top_value;
	logic [6:0]  depth;
	logic [1:0]  fault;

	// execution model state
	logic [31:0] stack_mem [STACK_WORDS];
	logic [31:0] local_mem [LOCAL_SLOTS];
	int          stack_ptr = 0;

	insn_t   pending_insns[$];
	result_t predicted_results[$];
	insn_t   cur_insn;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_under = 0;
	int n_over = 0;
	int n_taken = 0;
	int max_depth = 0;
	int quiet_cycles = 0;

	// stimulus shaping: depth the queued stream will reach, and the current depth goal
	int gen_depth = 0;
	int goal_depth = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	jvm_integer_stack_execute_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.imm          (imm),
		.local_index  (local_index),
		.branch_offset(branch_offset),
		.inst_addr    (inst_addr),
		.inst_len     (inst_len),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_addr    (next_addr),
		.top_value    (top_value),
		.depth        (depth),
		.fault        (fault)
	);

	initial begin
		foreach (stack_mem[i]) stack_mem[i] = '0;
		foreach (local_mem[i]) local_mem[i] = '0;
	end

	// execute one instruction against the model state and return its result word
	function automatic result_t execute_insn(insn_t w);
		int          need;
		bit          grows;
		bit          take;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] immx;
		logic [15:0] target;
		result_t     r;
		need = 0;
		grows = 1'b0;
		take = 1'b0;
		immx = {{16{w.imm[15]}}, w.imm};
		target = w.addr + w.boff;
		r.next_addr = w.addr + {14'd0, w.len};
		r.fault = FAULT_OK;
		case (w.op)
			OP_ADD, OP_MUL, OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGT, OP_IFLE, OP_IFGE: need = 2;
			OP_STORE, OP_DUP, OP_POP: need = 1;
			default: need = 0;
		endcase
		grows = (w.op == OP_PUSH) || (w.op == OP_LOAD) || (w.op == OP_DUP);
		if (stack_ptr < need)
			r.fault = FAULT_UNDER;
		else if (grows && stack_ptr >= STACK_WORDS)
			r.fault = FAULT_OVER;

		if (r.fault == FAULT_OK) begin
			case (w.op)
				OP_PUSH: begin
					stack_mem[stack_ptr] = immx;
					stack_ptr++;
				end
				OP_ADD: begin
					stack_mem[stack_ptr-2] = stack_mem[stack_ptr-2] + stack_mem[stack_ptr-1];
					stack_ptr--;
				end
				OP_MUL: begin
					stack_mem[stack_ptr-2] = stack_mem[stack_ptr-2] * stack_mem[stack_ptr-1];
					stack_ptr--;
				end
				OP_LOAD: begin
					stack_mem[stack_ptr] = local_mem[w.lidx];
					stack_ptr++;
				end
				OP_STORE: begin
					local_mem[w.lidx] = stack_mem[stack_ptr-1];
					stack_ptr--;
				end
				OP_DUP: begin
					stack_mem[stack_ptr] = stack_mem[stack_ptr-1];
					stack_ptr++;
				end
				OP_POP: stack_ptr--;
				OP_INC: local_mem[w.lidx] = local_mem[w.lidx] + immx;
				OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGT, OP_IFLE, OP_IFGE: begin
					b = stack_mem[stack_ptr-1];
					a = stack_mem[stack_ptr-2];
					stack_ptr -= 2;
					case (w.op)
						OP_IFEQ: take = (a == b);
						OP_IFNE: take = (a != b);
						OP_IFLT: take = ($signed(a) < $signed(b));
						OP_IFGT: take = ($signed(a) > $signed(b));
						OP_IFLE: take = ($signed(a) <= $signed(b));
						default: take = ($signed(a) >= $signed(b));
					endcase
					if (take) begin
						r.next_addr = target;
						n_taken++;
					end
				end
				OP_GOTO: r.next_addr = target;
				default: ;
			endcase
		end else begin
			r.next_addr = w.addr;
			if (r.fault == FAULT_UNDER)
				n_under++;
			else
				n_over++;
		end
		if (stack_ptr > max_depth)
			max_depth = stack_ptr;
		r.top = (stack_ptr > 0) ? stack_mem[stack_ptr-1] : '0;
		r.depth = 7'(stack_ptr);
		return r;
	endfunction

	// queue one instruction word and follow the depth it leaves behind
	task automatic add_insn(logic [3:0] op_c, logic [15:0] imm_v, logic [7:0] li,
			logic [15:0] off, logic [15:0] addr_v, logic [1:0] len_v);
		insn_t w;
		w = '{op: op_c, imm: imm_v, lidx: li, boff: off, addr: addr_v, len: len_v};
		pending_insns.push_back(w);
		n_queued++;
		case (op_c)
			OP_PUSH, OP_LOAD: if (gen_depth < STACK_WORDS) gen_depth++;
			OP_DUP: if (gen_depth >= 1 && gen_depth < STACK_WORDS) gen_depth++;
			OP_ADD, OP_MUL: if (gen_depth >= 2) gen_depth--;
			OP_STORE, OP_POP: if (gen_depth >= 1) gen_depth--;
			OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGT, OP_IFLE, OP_IFGE:
				if (gen_depth >= 2) gen_depth -= 2;
			default: ;
		endcase
	endtask

	// 16-bit value with extremes and small numbers favored, so compares hit equality
	function automatic logic [15:0] rand_half();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4, 5: return 16'($urandom_range(0, 6)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	// pick an operation that pushes the stack toward or away from the depth goal
	function automatic logic [3:0] pick_op(bit grow);
		if ($urandom_range(0, 99) < 12)
			return 4'($urandom_range(0, 15));
		if (grow) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: return OP_PUSH;
				4, 5, 6: return OP_LOAD;
				7, 8: return OP_DUP;
				default: return OP_INC;
			endcase
		end
		case ($urandom_range(0, 15))
			0, 1: return OP_ADD;
			2, 3: return OP_MUL;
			4, 5: return OP_STORE;
			6: return OP_POP;
			7: return OP_INC;
			8: return OP_GOTO;
			9: return OP_IFEQ;
			10: return OP_IFNE;
			11: return OP_IFLT;
			12: return OP_IFGT;
			13: return OP_IFLE;
			14: return OP_IFGE;
			default: return OP_LOAD;
		endcase
	endfunction

	// random stream in bursts: each burst aims at a low, high or middle stack depth
	task automatic queue_random(int count);
		logic [7:0]  li;
		logic [15:0] off;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(20, 60);
				case ($urandom_range(0, 3))
					0: goal_depth = $urandom_range(0, 2);
					1: goal_depth = STACK_WORDS + 2;
					default: goal_depth = $urandom_range(3, 40);
				endcase
			end
			burst_left--;
			li = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 7)) : 8'($urandom);
			off = $urandom_range(0, 1) ? rand_half() : 16'($urandom);
			add_insn(pick_op(gen_depth < goal_depth), rand_half(), li, off, 16'($urandom),
				2'($urandom_range(0, 3)));
		end
	endtask

	// wait until every queued word went in and every result came back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_accepted != n_queued || predicted_results.size() != 0);
	endtask

	function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	// driver: present the next pending word, predict when it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_results.push_back(execute_insn(cur_insn));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_insns.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_insn = pending_insns.pop_front();
					op <= cur_insn.op;
					imm <= cur_insn.imm;
					local_index <= cur_insn.lidx;
					branch_offset <= cur_insn.boff;
					inst_addr <= cur_insn.addr;
					inst_len <= cur_insn.len;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, check each result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result word, next_addr %h top %h depth %0d fault %0d",
						$time, next_addr, top_value, depth, fault);
					n_errors++;
				end else begin
					exp_r = predicted_results.pop_front();
					compare_field("next_addr", 32'(exp_r.next_addr), 32'(next_addr));
					compare_field("top_value", exp_r.top, top_value);
					compare_field("depth", 32'(exp_r.depth), 32'(depth));
					compare_field("fault", 32'(exp_r.fault), 32'(fault));
					n_checked++;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles in which no word moves on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
					quiet_cycles, predicted_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		// directed: faults on an empty stack
		add_insn(OP_POP, 16'h0000, 8'd0, 16'h0000, 16'h0010, 2'd1);
		add_insn(OP_ADD, 16'h0000, 8'd0, 16'h0000, 16'h0011, 2'd1);
		add_insn(OP_STORE, 16'h0000, 8'd7, 16'h0000, 16'h0012, 2'd2);
		add_insn(OP_DUP, 16'h0000, 8'd0, 16'h0000, 16'h0014, 2'd1);
		add_insn(OP_IFNE, 16'h0000, 8'd0, 16'h0040, 16'h0015, 2'd3);
		// extremes of the immediate, an add to -1, a wrapping multiply, one-entry underflow
		add_insn(OP_PUSH, 16'h7fff, 8'd0, 16'h0000, 16'hfffe, 2'd3);
		add_insn(OP_MUL, 16'h0000, 8'd0, 16'h0000, 16'h0001, 2'd1);
		add_insn(OP_PUSH, 16'h8000, 8'd0, 16'h0000, 16'h0002, 2'd3);
		add_insn(OP_ADD, 16'h0000, 8'd0, 16'h0000, 16'h0005, 2'd1);
		add_insn(OP_DUP, 16'h0000, 8'd0, 16'h0000, 16'h0006, 2'd1);
		add_insn(OP_MUL, 16'h0000, 8'd0, 16'h0000, 16'h0007, 2'd1);
		// top local slot: store, increment, load
		add_insn(OP_STORE, 16'h0000, 8'hff, 16'h0000, 16'h0008, 2'd2);
		add_insn(OP_INC, 16'h8000, 8'hff, 16'h0000, 16'h000a, 2'd3);
		add_insn(OP_LOAD, 16'h0000, 8'hff, 16'h0000, 16'h000d, 2'd2);
		// branches: taken with wrap, equal taken, not taken with zero length
		add_insn(OP_PUSH, 16'hffff, 8'd0, 16'h0000, 16'h000f, 2'd3);
		add_insn(OP_IFLT, 16'h0000, 8'd0, 16'h8000, 16'h0000, 2'd3);
		add_insn(OP_PUSH, 16'h0005, 8'd0, 16'h0000, 16'h0100, 2'd2);
		add_insn(OP_PUSH, 16'h0005, 8'd0, 16'h0000, 16'h0102, 2'd2);
		add_insn(OP_IFEQ, 16'h0000, 8'd0, 16'h7fff, 16'hffff, 2'd3);
		add_insn(OP_PUSH, 16'h0003, 8'd0, 16'h0000, 16'h0200, 2'd2);
		add_insn(OP_PUSH, 16'h0005, 8'd0, 16'h0000, 16'h0202, 2'd2);
		add_insn(OP_IFGE, 16'h0000, 8'd0, 16'h0010, 16'h0204, 2'd0);
		add_insn(OP_GOTO, 16'h0000, 8'd0, 16'h7fff, 16'hffff, 2'd3);
		add_insn(OP_UNUSED, 16'hffff, 8'hff, 16'hffff, 16'h1234, 2'd0);
		// untouched local reads zero, then a less-or-equal on equal values
		add_insn(OP_LOAD, 16'h0000, 8'd0, 16'h0000, 16'h0300, 2'd2);
		add_insn(OP_DUP, 16'h0000, 8'd0, 16'h0000, 16'h0302, 2'd1);
		add_insn(OP_IFLE, 16'h0000, 8'd0, 16'hfff0, 16'h0303, 2'd3);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// random phases: free flow, sender idling, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			queue_random(RANDOM_PER_PH);
			wait_drained();
		end

		// let any stray result word show up
		repeat (10) @(posedge clk);
		$display("checked %0d results over four flow phases: %0d underflows, %0d overflows,",
			n_checked, n_under, n_over);
		$display("%0d branches taken, deepest stack %0d, %0d errors", n_taken, max_depth,
			n_errors);
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/jise_pkg.sv
rtl/core/jise_stack_mem.sv
rtl/core/jise_local_mem.sv
rtl/core/jvm_integer_stack_execute_core.sv
dv/jvm_integer_stack_execute_core_tb.sv
